>>> design/ttd_pkg.sv
// Shared types, codes and constants of the touch tap detector.
`timescale 1ns / 1ps

package ttd_pkg;

    localparam int RAW_W      = 16;
    localparam int TIME_W     = 32;
    localparam int CMD_W      = 3;
    localparam int SX_W       = 10;
    localparam int SY_W       = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MODE_W     = 3;

    localparam int SCREEN_W_DEF = 800;
    localparam int SCREEN_H_DEF = 480;

    // Raw coordinate resolution of the touch controller.
    localparam int COORD_BITS = 16;
    localparam logic [RAW_W-1:0] COORD_MASK = RAW_W'((64'd1 << COORD_BITS) - 64'd1);

    typedef enum logic [CMD_W-1:0] {
        CMD_PRESS      = 3'd0,
        CMD_RELEASE    = 3'd1,
        CMD_AXIS_X     = 3'd2,
        CMD_AXIS_Y     = 3'd3,
        CMD_AXIS_OTHER = 3'd4,
        CMD_IGNORED    = 3'd5
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] REG_X_RAW_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_RAW_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_RAW_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_RAW_MAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_MODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_LIMIT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MIN_MS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MAX_MS = 3'd7;

    localparam logic [RAW_W-1:0]  X_RAW_MIN_RST   = 16'd0;
    localparam logic [RAW_W-1:0]  X_RAW_MAX_RST   = 16'd4095;
    localparam logic [RAW_W-1:0]  Y_RAW_MIN_RST   = 16'd0;
    localparam logic [RAW_W-1:0]  Y_RAW_MAX_RST   = 16'd4095;
    localparam logic [MODE_W-1:0] AXIS_MODE_RST   = 3'd0;
    localparam logic [RAW_W-1:0]  MOVE_LIMIT_RST  = 16'd50;
    localparam logic [RAW_W-1:0]  HOLD_MIN_MS_RST = 16'd0;
    localparam logic [RAW_W-1:0]  HOLD_MAX_MS_RST = 16'd1000;

    localparam int MODE_INV_X = 0;
    localparam int MODE_INV_Y = 1;
    localparam int MODE_SWAP  = 2;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [RAW_W-1:0]  axis_value;
        logic [TIME_W-1:0] time_ms;
    } in_t;

    typedef struct packed {
        logic [RAW_W-1:0] tap_raw_x;
        logic [RAW_W-1:0] tap_raw_y;
        logic [SX_W-1:0]  tap_screen_x;
        logic [SY_W-1:0]  tap_screen_y;
    } out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MAP
    } top_state_t;

    typedef enum logic [1:0] {
        MAP_IDLE,
        MAP_CLAMP,
        MAP_MUL,
        MAP_DIV
    } map_state_t;

endpackage

>>> design/ttd_axis_map.sv
// One calibration axis: clamp, invert, scale and bit-serial restoring divide.
`timescale 1ns / 1ps

module ttd_axis_map
    import ttd_pkg::*;
#(
    parameter int SPAN = SCREEN_W_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [RAW_W-1:0]            raw,
    input  logic [RAW_W-1:0]            lo,
    input  logic [RAW_W-1:0]            hi,
    input  logic                        inv,
    output logic                        done,
    output logic [$clog2(SPAN)-1:0]     result
);

    localparam int QW = $clog2(SPAN);
    localparam int PW = RAW_W + QW;
    localparam int CW = $clog2(PW);

    map_state_t          state_reg, state_next;
    logic [RAW_W-1:0]    num_reg, num_next;
    logic [RAW_W-1:0]    den_reg, den_next;
    logic                zero_reg, zero_next;
    logic                inv_reg, inv_next;
    logic [PW-1:0]       prod_reg, prod_next;
    logic [RAW_W-1:0]    rem_reg, rem_next;
    logic [QW-1:0]       q_reg, q_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                done_reg, done_next;

    logic [RAW_W:0]      trial;
    logic                ge;
    logic [RAW_W-1:0]    clamped;

    always_comb
    begin
        trial   = {rem_reg, prod_reg[PW-1]};
        ge      = trial >= {1'b0, den_reg};
        clamped = (num_reg > den_reg) ? den_reg : num_reg;

        state_next = state_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        zero_next  = zero_reg;
        inv_next   = inv_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;

        unique case (state_reg)
            MAP_IDLE:
            begin
                if (start)
                begin
                    // Flip both signs for reversed bounds; quotient is unchanged.
                    if (hi > lo)
                    begin
                        den_next = hi - lo;
                        num_next = (raw < lo) ? '0 : raw - lo;
                    end
                    else
                    begin
                        den_next = lo - hi;
                        num_next = (raw > lo) ? '0 : lo - raw;
                    end
                    zero_next  = hi == lo;
                    inv_next   = inv;
                    state_next = MAP_CLAMP;
                end
            end
            MAP_CLAMP:
            begin
                num_next   = inv_reg ? den_reg - clamped : clamped;
                state_next = MAP_MUL;
            end
            MAP_MUL:
            begin
                prod_next  = PW'(num_reg) * PW'(SPAN - 1);
                rem_next   = '0;
                q_next     = '0;
                cnt_next   = CW'(PW - 1);
                state_next = MAP_DIV;
            end
            MAP_DIV:
            begin
                // One quotient bit per cycle, dividend fed MSB first.
                rem_next  = ge ? RAW_W'(trial - {1'b0, den_reg}) : trial[RAW_W-1:0];
                prod_next = {prod_reg[PW-2:0], 1'b0};
                q_next    = QW'({q_reg, ge});
                cnt_next  = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = MAP_IDLE;
                end
            end
            default:
            begin
                state_next = MAP_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MAP_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        zero_reg <= zero_next;
        inv_reg  <= inv_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
    end

    assign done   = done_reg;
    assign result = zero_reg ? '0 : q_reg;

endmodule

>>> design/touch_tap_detector.sv
// Top level of the touch tap detector: event tracking, tap qualification, output register.
`timescale 1ns / 1ps

// Touch tap detector. Each input transaction is one touch event (press, release,
// X or Y axis value, other axis, ignored) with a millisecond timestamp. Press,
// axis and ignored events, and releases with no touch active, are taken without
// leaving idle. A release of an active touch is qualified in the following
// cycle (captured start, largest raw movement within move_limit, hold time
// within [hold_min_ms, hold_max_ms]); a qualified tap then runs both
// calibration axes in parallel through bit-serial restoring dividers, one
// quotient bit per cycle, and in_stall stays high until both results are in
// and the output register is free to take them. The result sits in an output
// register, so the next event is taken while a tap waits for the consumer.
// Configuration is a plain write port (index 0..7 in register order); write
// only while idle.
module touch_tap_detector
    import ttd_pkg::*;
#(
    parameter int SCREEN_W = SCREEN_W_DEF,
    parameter int SCREEN_H = SCREEN_H_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_t                   in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_t                  out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int QX_W = $clog2(SCREEN_W);
    localparam int QY_W = $clog2(SCREEN_H);

    // Calibration and gesture limits.
    logic [RAW_W-1:0]  x_raw_min_reg, x_raw_max_reg, y_raw_min_reg, y_raw_max_reg;
    logic [MODE_W-1:0] axis_mode_reg;
    logic [RAW_W-1:0]  move_limit_reg, hold_min_ms_reg, hold_max_ms_reg;

    // Touch tracking state.
    top_state_t        state_reg, state_next;
    logic              touch_active_reg, touch_active_next;
    logic              start_captured_reg, start_captured_next;
    logic [TIME_W-1:0] press_time_reg, press_time_next;
    logic [RAW_W-1:0]  start_x_reg, start_x_next;
    logic [RAW_W-1:0]  start_y_reg, start_y_next;
    logic [RAW_W-1:0]  latest_x_reg, latest_x_next;
    logic [RAW_W-1:0]  latest_y_reg, latest_y_next;

    // Release qualification.
    logic [TIME_W-1:0] held_reg, held_next;
    logic [RAW_W-1:0]  mx_reg, mx_next;
    logic [RAW_W-1:0]  my_reg, my_next;

    // Mapping progress and output register.
    logic              x_fin_reg, x_fin_next;
    logic              y_fin_reg, y_fin_next;
    logic              out_valid_reg, out_valid_next;
    out_t              out_reg, out_next;

    logic              in_take;
    logic [RAW_W-1:0]  val;
    logic [RAW_W-1:0]  new_x, new_y;
    logic [RAW_W-1:0]  mv;
    logic              tap_ok;
    logic              map_start;
    logic              swap;
    logic              x_done, y_done;
    logic [QX_W-1:0]   x_result;
    logic [QY_W-1:0]   y_result;
    logic              x_fin, y_fin;
    logic              out_free;
    logic              out_load;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_raw_min_reg   <= X_RAW_MIN_RST;
            x_raw_max_reg   <= X_RAW_MAX_RST;
            y_raw_min_reg   <= Y_RAW_MIN_RST;
            y_raw_max_reg   <= Y_RAW_MAX_RST;
            axis_mode_reg   <= AXIS_MODE_RST;
            move_limit_reg  <= MOVE_LIMIT_RST;
            hold_min_ms_reg <= HOLD_MIN_MS_RST;
            hold_max_ms_reg <= HOLD_MAX_MS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_X_RAW_MIN:   x_raw_min_reg   <= cfg_data;
                REG_X_RAW_MAX:   x_raw_max_reg   <= cfg_data;
                REG_Y_RAW_MIN:   y_raw_min_reg   <= cfg_data;
                REG_Y_RAW_MAX:   y_raw_max_reg   <= cfg_data;
                REG_AXIS_MODE:   axis_mode_reg   <= cfg_data[MODE_W-1:0];
                REG_MOVE_LIMIT:  move_limit_reg  <= cfg_data;
                REG_HOLD_MIN_MS: hold_min_ms_reg <= cfg_data;
                REG_HOLD_MAX_MS: hold_max_ms_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Take events only when no tap is in flight.
    assign in_stall = state_reg != ST_IDLE;
    assign in_take  = in_valid && !in_stall;

    assign val   = in_data.axis_value & COORD_MASK;
    assign new_x = (in_data.cmd == CMD_AXIS_X) ? val : latest_x_reg;
    assign new_y = (in_data.cmd == CMD_AXIS_Y) ? val : latest_y_reg;

    assign mv     = (mx_reg > my_reg) ? mx_reg : my_reg;
    assign tap_ok = start_captured_reg && (mv <= move_limit_reg)
                    && (held_reg >= TIME_W'(hold_min_ms_reg))
                    && (held_reg <= TIME_W'(hold_max_ms_reg));

    assign map_start = (state_reg == ST_CHECK) && tap_ok;
    assign swap      = axis_mode_reg[MODE_SWAP];

    assign x_fin    = x_fin_reg || x_done;
    assign y_fin    = y_fin_reg || y_done;
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = (state_reg == ST_MAP) && x_fin && y_fin && out_free;

    always_comb
    begin
        state_next          = state_reg;
        touch_active_next   = touch_active_reg;
        start_captured_next = start_captured_reg;
        press_time_next     = press_time_reg;
        start_x_next        = start_x_reg;
        start_y_next        = start_y_reg;
        latest_x_next       = latest_x_reg;
        latest_y_next       = latest_y_reg;
        held_next           = held_reg;
        mx_next             = mx_reg;
        my_next             = my_reg;
        x_fin_next          = x_fin_reg;
        y_fin_next          = y_fin_reg;
        out_next            = out_reg;
        out_valid_next      = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    case (in_data.cmd) inside
                        CMD_PRESS:
                        begin
                            // Restart the touch and drop any held start.
                            touch_active_next   = 1'b1;
                            start_captured_next = 1'b0;
                            press_time_next     = in_data.time_ms;
                        end
                        CMD_RELEASE:
                        begin
                            if (touch_active_reg)
                            begin
                                touch_active_next = 1'b0;
                                held_next  = in_data.time_ms - press_time_reg;
                                mx_next    = (latest_x_reg >= start_x_reg)
                                             ? latest_x_reg - start_x_reg
                                             : start_x_reg - latest_x_reg;
                                my_next    = (latest_y_reg >= start_y_reg)
                                             ? latest_y_reg - start_y_reg
                                             : start_y_reg - latest_y_reg;
                                state_next = ST_CHECK;
                            end
                        end
                        CMD_AXIS_X, CMD_AXIS_Y, CMD_AXIS_OTHER:
                        begin
                            // Other axis codes still capture the start position.
                            if (touch_active_reg)
                            begin
                                latest_x_next = new_x;
                                latest_y_next = new_y;
                                if (!start_captured_reg)
                                begin
                                    start_x_next        = new_x;
                                    start_y_next        = new_y;
                                    start_captured_next = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                x_fin_next = 1'b0;
                y_fin_next = 1'b0;
                state_next = tap_ok ? ST_MAP : ST_IDLE;
            end
            ST_MAP:
            begin
                // Hold finished axes until both are in and the output is free.
                x_fin_next = x_fin;
                y_fin_next = y_fin;
                if (out_load)
                begin
                    out_next.tap_raw_x    = latest_x_reg;
                    out_next.tap_raw_y    = latest_y_reg;
                    out_next.tap_screen_x = SX_W'(x_result);
                    out_next.tap_screen_y = SY_W'(y_result);
                    out_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            touch_active_reg   <= 1'b0;
            start_captured_reg <= 1'b0;
            press_time_reg     <= '0;
            start_x_reg        <= '0;
            start_y_reg        <= '0;
            latest_x_reg       <= '0;
            latest_y_reg       <= '0;
            x_fin_reg          <= 1'b0;
            y_fin_reg          <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            touch_active_reg   <= touch_active_next;
            start_captured_reg <= start_captured_next;
            press_time_reg     <= press_time_next;
            start_x_reg        <= start_x_next;
            start_y_reg        <= start_y_next;
            latest_x_reg       <= latest_x_next;
            latest_y_reg       <= latest_y_next;
            x_fin_reg          <= x_fin_next;
            y_fin_reg          <= y_fin_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        out_reg  <= out_next;
    end

    // Column runs through the X calibration, row through the Y calibration;
    // swap exchanges which raw axis feeds each.
    ttd_axis_map #(
        .SPAN (SCREEN_W)
    ) u_map_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (map_start),
        .raw    (swap ? latest_y_reg : latest_x_reg),
        .lo     (x_raw_min_reg),
        .hi     (x_raw_max_reg),
        .inv    (axis_mode_reg[MODE_INV_X]),
        .done   (x_done),
        .result (x_result)
    );

    ttd_axis_map #(
        .SPAN (SCREEN_H)
    ) u_map_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (map_start),
        .raw    (swap ? latest_x_reg : latest_y_reg),
        .lo     (y_raw_min_reg),
        .hi     (y_raw_max_reg),
        .inv    (axis_mode_reg[MODE_INV_Y]),
        .done   (y_done),
        .result (y_result)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef ASSERT_OFF
    // An accepted release of an active touch always goes to qualification.
    a_release_checks: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && (in_data.cmd == CMD_RELEASE) && touch_active_reg
        |=> state_reg == ST_CHECK)
        else $error("release of active touch not qualified");

    // Qualification lasts exactly one cycle.
    a_check_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CHECK |=> state_reg != ST_CHECK)
        else $error("qualification stuck");

    // A new tap appears only at the end of a mapping run.
    a_tap_from_map: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_MAP)
        else $error("tap result without mapping");

    // No touch is active while a tap is being mapped.
    a_map_inactive: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MAP |-> !touch_active_reg)
        else $error("touch active during mapping");
`endif

endmodule
